FILE: sv/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types, tables and round functions of the byte Feistel block cipher
// (64-bit block, 128-bit key, eight byte branches).
// ----------------------------------------------------------------------------
package bfc_pkg;

    localparam int BFC_ROUND_COUNT = 20;
    localparam int BLOCK_W         = 64;
    localparam int KEY_HALF_W      = 64;
    localparam int CFG_INDEX_W     = 2;

    typedef logic [7:0]           byte_t;
    typedef logic [BLOCK_W-1:0]   block_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // configuration register indexes
    localparam cfg_index_t REG_KEY_UPPER = 2'd0;
    localparam cfg_index_t REG_KEY_LOWER = 2'd1;

    localparam logic [3:0] SBOX [16] = '{
        4'h4, 4'h5, 4'hE, 4'h9, 4'hB, 4'h8, 4'hD, 4'hA,
        4'hF, 4'hC, 4'h3, 4'h6, 4'h1, 4'h0, 4'h7, 4'h2
    };

    localparam logic [2:0] BIT_MOVE [8] = '{
        3'd1, 3'd7, 3'd4, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6
    };

    // constant subkeys that whiten the two key halves
    localparam block_t WHITE_A = 64'hda316f589fcb7cf7;
    localparam block_t WHITE_B = 64'h92b12edd1c54aa80;

    localparam logic [4:0] KS_ODD_XOR = 5'h0B;

    // F: key xor, nibble sboxes, bit permutation
    function automatic byte_t ffun(byte_t x, byte_t k);
        byte_t v;
        byte_t s;
        byte_t o;
        v = x ^ k;
        s = {SBOX[v[7:4]], SBOX[v[3:0]]};
        o = '0;
        for (int i = 0; i < 8; i++) begin
            o[3'd7 - BIT_MOVE[i]] = s[3'(7 - i)];
        end
        return o;
    endfunction

    function automatic block_t enc_round(block_t w, block_t k, logic last);
        byte_t p [8];
        byte_t kb [8];
        byte_t f [8];
        byte_t t [8];
        block_t r;
        for (int i = 0; i < 8; i++) begin
            p[i]  = w[63-8*i -: 8];
            kb[i] = k[63-8*i -: 8];
        end
        f[0] = ffun(p[0], kb[0]);
        f[1] = ffun(p[2], kb[1]);
        f[2] = ffun(p[4], kb[2]);
        f[3] = ffun(p[6], kb[3]);
        f[4] = ffun(f[1] ^ p[3], kb[4]);
        f[5] = ffun(f[0] ^ p[1], kb[5]);
        f[6] = ffun(f[3] ^ p[7], kb[6]);
        f[7] = ffun(f[2] ^ p[5], kb[7]);
        if (!last) begin
            t[0] = f[5] ^ p[2]; t[1] = f[7] ^ p[6];
            t[2] = f[0] ^ p[1]; t[3] = f[6] ^ p[4];
            t[4] = f[3] ^ p[7]; t[5] = f[4] ^ p[0];
            t[6] = f[1] ^ p[3]; t[7] = f[2] ^ p[5];
        end else begin
            t[0] = f[1] ^ p[3]; t[1] = f[4] ^ p[0];
            t[2] = f[0] ^ p[1]; t[3] = f[5] ^ p[2];
            t[4] = f[3] ^ p[7]; t[5] = f[6] ^ p[4];
            t[6] = f[2] ^ p[5]; t[7] = f[7] ^ p[6];
        end
        r = {t[0], t[1], t[2], t[3], t[4], t[5], t[6], t[7]};
        return r;
    endfunction

    function automatic block_t dec_round(block_t w, block_t k, logic last);
        byte_t n [8];
        byte_t kb [8];
        byte_t f [8];
        byte_t p [8];
        byte_t x [8];
        block_t r;
        for (int i = 0; i < 8; i++) begin
            n[i]  = w[63-8*i -: 8];
            kb[i] = k[63-8*i -: 8];
        end
        if (!last) begin
            x[0] = n[5]; x[1] = n[2]; x[2] = n[0]; x[3] = n[6];
            x[4] = n[3]; x[5] = n[7]; x[6] = n[1]; x[7] = n[4];
        end else begin
            x[0] = n[1]; x[1] = n[2]; x[2] = n[3]; x[3] = n[0];
            x[4] = n[5]; x[5] = n[6]; x[6] = n[7]; x[7] = n[4];
        end
        f[4] = ffun(x[3], kb[4]);
        f[5] = ffun(x[1], kb[5]);
        f[6] = ffun(x[7], kb[6]);
        f[7] = ffun(x[5], kb[7]);
        p[0] = f[4] ^ x[0];
        p[2] = f[5] ^ x[2];
        p[4] = f[6] ^ x[4];
        p[6] = f[7] ^ x[6];
        f[0] = ffun(p[0], kb[0]);
        f[1] = ffun(p[2], kb[1]);
        f[2] = ffun(p[4], kb[2]);
        f[3] = ffun(p[6], kb[3]);
        p[1] = f[0] ^ x[1];
        p[3] = f[1] ^ x[3];
        p[5] = f[2] ^ x[5];
        p[7] = f[3] ^ x[7];
        r = {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]};
        return r;
    endfunction

endpackage

FILE: sv/bfc_key_sched.sv
// ----------------------------------------------------------------------------
// bfc_key_sched
// Key registers and subkey expansion: a whitening step, then one subkey
// per cycle while no configuration write arrives, into a register bank that the round stages read.
// ----------------------------------------------------------------------------
module bfc_key_sched
    import bfc_pkg::*;
#(
    parameter int ROUND_COUNT = BFC_ROUND_COUNT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  cfg_index_t       cfg_index,
    input  logic [KEY_HALF_W-1:0] cfg_data,
    output logic             key_ready,
    output block_t           subkeys [ROUND_COUNT]
);

    localparam int CNT_W = $clog2(ROUND_COUNT);

    typedef enum logic [1:0] {
        KS_LOAD,
        KS_EXPAND,
        KS_DONE
    } ks_state_t;

    ks_state_t              state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [KEY_HALF_W-1:0]  key_upper_reg;
    logic [KEY_HALF_W-1:0]  key_lower_reg;
    logic [127:0]           ks_reg;
    logic [127:0]           ks_next;
    block_t                 subkey_next;
    block_t                 sk_reg [ROUND_COUNT];

    // even steps rotate by 17 and sbox one nibble, odd steps rotate by 61 and xor a constant
    always_comb begin
        if (!cnt_reg[0]) begin
            ks_next      = {ks_reg[110:0], ks_reg[127:111]};
            ks_next[7:4] = SBOX[ks_next[7:4]];
            subkey_next  = ks_next[63:0];
        end else begin
            ks_next          = {ks_reg[66:0], ks_reg[127:67]};
            ks_next[115:111] = ks_next[115:111] ^ KS_ODD_XOR;
            subkey_next      = ks_next[127:64];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= KS_LOAD;
            cnt_reg       <= '0;
            key_upper_reg <= '0;
            key_lower_reg <= '0;
            ks_reg        <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_KEY_UPPER: begin
                    key_upper_reg <= cfg_data;
                    state_reg     <= KS_LOAD;
                end
                REG_KEY_LOWER: begin
                    key_lower_reg <= cfg_data;
                    state_reg     <= KS_LOAD;
                end
                default: ;
            endcase
        end else begin
            unique case (state_reg)
                KS_LOAD: begin
                    ks_reg    <= {enc_round(key_upper_reg, WHITE_A, 1'b0),
                                  enc_round(key_lower_reg, WHITE_B, 1'b0)};
                    cnt_reg   <= '0;
                    state_reg <= KS_EXPAND;
                end
                KS_EXPAND: begin
                    ks_reg  <= ks_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(ROUND_COUNT - 1)) begin
                        state_reg <= KS_DONE;
                    end
                end
                KS_DONE: ;
                default: state_reg <= KS_LOAD;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == KS_EXPAND && !cfg_valid) begin
            sk_reg[cnt_reg] <= subkey_next;
        end
    end

    assign key_ready = (state_reg == KS_DONE);
    assign subkeys   = sk_reg;

endmodule

FILE: sv/bfc_round_stage.sv
// ----------------------------------------------------------------------------
// bfc_round_stage
// One pipeline stage: a single encrypt or decrypt round and its register,
// with a valid bit and the direction traveling alongside the block.
// ----------------------------------------------------------------------------
module bfc_round_stage
    import bfc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   load_en,
    input  logic   valid_in,
    input  logic   action_in,
    input  block_t block_in,
    input  block_t subkey,
    input  logic   last,
    output logic   valid_q,
    output logic   action_q,
    output block_t block_q
);

    logic   valid_reg;
    logic   action_reg;
    block_t block_reg;
    block_t block_next;

    always_comb begin
        if (action_in) begin
            block_next = dec_round(block_in, subkey, last);
        end else begin
            block_next = enc_round(block_in, subkey, last);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en && valid_in) begin
            action_reg <= action_in;
            block_reg  <= block_next;
        end
    end

    assign valid_q  = valid_reg;
    assign action_q = action_reg;
    assign block_q  = block_reg;

endmodule

FILE: sv/byte_feistel_block_cipher_64_128_core.sv
// ----------------------------------------------------------------------------
// Each input transaction passes through the pipeline stages to m_valid, one round
// per pipeline stage; throughput one block per cycle, stages hold on stall.
// After reset and after every key register write the subkey expansion runs
// a whitening step and then one step per subkey, during which s_ready stays low.
// Reset clears the key registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
// byte_feistel_block_cipher_64_128_core
// 64-bit block, 128-bit key generalized Feistel cipher, fully pipelined.
// ----------------------------------------------------------------------------
module byte_feistel_block_cipher_64_128_core
    import bfc_pkg::*;
#(
    parameter int ROUND_COUNT = BFC_ROUND_COUNT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_index_t            cfg_index,
    input  logic [KEY_HALF_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  block_t                s_block_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output block_t                m_block_out
);

    logic   key_ready;
    block_t subkeys [ROUND_COUNT];

    logic   pipe_valid  [ROUND_COUNT+1];
    logic   pipe_action [ROUND_COUNT+1];
    block_t pipe_block  [ROUND_COUNT+1];
    logic   stage_en    [ROUND_COUNT+1];

    bfc_key_sched #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_key_sched (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_ready (key_ready),
        .subkeys   (subkeys)
    );

    assign cfg_ready = 1'b1;

    // a stage loads when it is empty or the next one loads
    assign stage_en[ROUND_COUNT] = m_ready;
    assign s_ready        = stage_en[0] && key_ready;
    assign pipe_valid[0]  = s_valid && s_ready;
    assign pipe_action[0] = s_action;
    assign pipe_block[0]  = s_block_in;

    for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_stage
        localparam int DEC_IDX = ROUND_COUNT - 1 - i;
        block_t stage_key;
        logic   stage_last;

        // decryption walks the subkeys backward and starts on the last round
        assign stage_key  = pipe_action[i] ? subkeys[DEC_IDX] : subkeys[i];
        assign stage_last = pipe_action[i] ? 1'(i == 0) : 1'(i == ROUND_COUNT - 1);
        assign stage_en[i] = !pipe_valid[i+1] || stage_en[i+1];

        bfc_round_stage u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load_en   (stage_en[i]),
            .valid_in  (pipe_valid[i]),
            .action_in (pipe_action[i]),
            .block_in  (pipe_block[i]),
            .subkey    (stage_key),
            .last      (stage_last),
            .valid_q   (pipe_valid[i+1]),
            .action_q  (pipe_action[i+1]),
            .block_q   (pipe_block[i+1])
        );
    end

    assign m_valid     = pipe_valid[ROUND_COUNT];
    assign m_block_out = pipe_block[ROUND_COUNT];

endmodule
